// File: design/isr_pkg.sv
// ============================================================================
// isr_pkg
// Shared types and constants for the first-seen index renumbering block.
// ============================================================================
`default_nettype none

package isr_pkg;

    // Field widths of the stream beats.
    localparam int SRC_W = 16;
    localparam int NUM_W = 16;

    // The free-number counter holds one more bit so it can reach the limit.
    localparam int COUNT_W = NUM_W + 1;
    localparam logic [COUNT_W-1:0] NUMBER_LIMIT = COUNT_W'(1) << NUM_W;

    // Local number returned when numbering is exhausted.
    localparam logic [NUM_W-1:0] EXHAUSTED_NUMBER = '1;

    // Sequencer states: the clearing pass after reset and the steps of one beat.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_NUM,
        ST_RESOLVE
    } isr_state_t;

endpackage : isr_pkg

`default_nettype wire

// File: design/isr_stream_if.sv
// ============================================================================
// isr_stream_if
// Valid/ready channels for source-index beats and renumbered result beats.
// ============================================================================
`default_nettype none

interface isr_in_if;
    import isr_pkg::*;

    logic             valid;
    logic             ready;
    logic [SRC_W-1:0] vertex_id;
    logic             first_of_mesh;

    modport source (output valid, output vertex_id, output first_of_mesh, input ready);
    modport sink   (input valid, input vertex_id, input first_of_mesh, output ready);
endinterface : isr_in_if

interface isr_out_if;
    import isr_pkg::*;

    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] compact_id;
    logic             is_new;
    logic [SRC_W-1:0] source_echo;

    modport source (output valid, output compact_id, output is_new, output source_echo,
                    input ready);
    modport sink   (input valid, input compact_id, input is_new, input source_echo,
                    output ready);
endinterface : isr_out_if

`default_nettype wire

// File: design/index_first_seen_renumber.sv
// ============================================================================
// index_first_seen_renumber
// Renumbers a stream of source vertex indices into a compact local numbering.
// ============================================================================
//
// Each input beat carries one source index; the block answers it with exactly
// one result beat holding the local number, a flag that is set on the first
// occurrence of the index within the current mesh, and the source index
// echoed back. A beat with first_of_mesh set starts a new mesh: numbering
// restarts at zero and every earlier index counts as unseen. Membership is
// kept as a sparse set in two synchronous memories: the forward table maps a
// source index to its number and the reverse table maps a number back to the
// source index that owns it. An index counts as seen only when its stored
// number lies below the free-number counter and the reverse table points back
// at it, so a new mesh starts without clearing any memory between meshes.
// After reset the block runs one clearing pass that writes zero into every
// forward-table entry, one entry per cycle; input ready stays low until that
// pass ends. For an item, the forward read is issued on the accepting edge,
// the reverse read at the stored number in ST_READ_NUM, and the decision
// with its write-back to both tables in ST_RESOLVE; the reverse read depends
// on the result of the forward read. ST_RESOLVE waits while the output
// register still holds a result the sink has not taken. Only one item is in
// flight at a time, so no read can meet an outstanding write to the same
// entry. The result sits in an output register, so the next input beat is
// taken while that result still waits for the sink. When the table is
// narrower than 16 bits, indices differing only in high bits share an entry.
// Once 65536 numbers are handed out, an unseen index returns all ones with
// the new flag clear and changes nothing.
//
`default_nettype none

module index_first_seen_renumber #(
    parameter int SOURCE_INDEX_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    isr_in_if.sink    items,
    isr_out_if.source results
);
    import isr_pkg::*;

    localparam int IDX_W       = SOURCE_INDEX_BITS;
    localparam int TABLE_DEPTH = 2 ** IDX_W;
    localparam int REV_DEPTH   = 2 ** NUM_W;

    // Forward table: source slot -> local number.
    logic [NUM_W-1:0] number_mem [TABLE_DEPTH];
    // Reverse table: local number -> source slot.
    logic [IDX_W-1:0] owner_mem [REV_DEPTH];

    isr_state_t state_reg, state_next;

    logic [IDX_W-1:0]   clear_addr_reg, clear_addr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SRC_W-1:0]   src_reg;
    logic               first_reg;
    logic [NUM_W-1:0]   number_q;
    logic [IDX_W-1:0]   owner_q;

    logic               out_valid_reg, out_valid_next;
    logic [NUM_W-1:0]   out_local_reg;
    logic               out_new_reg;
    logic [SRC_W-1:0]   out_echo_reg;

    logic               accept;
    logic               clearing;
    logic               load_out;
    logic [IDX_W-1:0]   in_slot;
    logic [IDX_W-1:0]   slot;
    logic [COUNT_W-1:0] count_eff;
    logic               seen;
    logic               fresh;
    logic [NUM_W-1:0]   local_value;

    assign items.ready = (state_reg == ST_IDLE);
    assign accept      = items.valid && items.ready;
    assign clearing    = (state_reg == ST_CLEAR);
    assign in_slot     = IDX_W'(items.vertex_id);
    assign slot        = IDX_W'(src_reg);

    // A mesh start discards all earlier entries and restarts at zero.
    assign count_eff = first_reg ? '0 : count_reg;
    assign seen      = !first_reg
                       && ({1'b0, number_q} < count_reg)
                       && (owner_q == slot);
    assign fresh       = !seen && (count_eff < NUMBER_LIMIT);
    assign local_value = seen  ? number_q
                       : fresh ? count_eff[NUM_W-1:0]
                       : EXHAUSTED_NUMBER;

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        load_out        = 1'b0;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;

        if (results.valid && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // One forward-table entry is zeroed per cycle.
                clear_addr_next = clear_addr_reg + IDX_W'(1);
                if (clear_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ_NUM;
                end
            end
            ST_READ_NUM:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                // Finish only when the output register is free this cycle.
                if (!out_valid_reg || results.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    count_next     = count_eff + COUNT_W'(fresh);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg   <= items.vertex_id;
            first_reg <= items.first_of_mesh;
        end
        if (load_out)
        begin
            out_local_reg <= local_value;
            out_new_reg   <= fresh;
            out_echo_reg  <= src_reg;
        end
    end

    // Forward table port: zeroed once after reset, read on accept, written
    // when a new number is granted.
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            number_mem[clear_addr_reg] <= '0;
        end
        else if (load_out && fresh)
        begin
            number_mem[slot] <= count_eff[NUM_W-1:0];
        end
        if (accept)
        begin
            number_q <= number_mem[in_slot];
        end
    end

    // Reverse table port: read at the stored number, write the new owner.
    always_ff @(posedge clk)
    begin
        if (load_out && fresh)
        begin
            owner_mem[count_eff[NUM_W-1:0]] <= slot;
        end
        if (state_reg == ST_READ_NUM)
        begin
            owner_q <= owner_mem[number_q];
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.compact_id  = out_local_reg;
    assign results.is_new      = out_new_reg;
    assign results.source_echo = out_echo_reg;

`ifndef ASSERT_OFF
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NUMBER_LIMIT)
        else $error("free-number counter ran past the limit");

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_READ_NUM)
        else $error("accepted beat did not start a table read");

    a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && fresh) |=> count_reg == ({1'b0, results.compact_id} + COUNT_W'(1)))
        else $error("new number and counter disagree");

    a_mesh_start_new: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && first_reg) |-> (fresh && local_value == '0))
        else $error("first beat of a mesh was not numbered zero");

    a_out_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> results.valid)
        else $error("finished beat did not reach the output");
`endif

endmodule : index_first_seen_renumber

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the first-seen index renumbering block. Directed
// beats from a table are followed by random meshes. Every result beat is
// compared with a local prediction of the renumbering, while both channels
// idle at random.
// ============================================================================

module testbench;
    import isr_pkg::*;

    // The table width the block is built with. The prediction masks the source
    // index the same way, so a narrower table aliases here as it does there.
    localparam int TABLE_BITS = 16;
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;

    // Least number of random source beats after the directed part; the last mesh runs to its end.
    localparam int RANDOM_BEATS = 2000;

    // Cycles to keep watching after the last expected result, enough to catch
    // any stray result beat.
    localparam int SETTLE_CYCLES = 12;

    // Only this many mismatches are printed in full.
    localparam int MAX_REPORTS = 10;

    // One renumbered result beat as the sink sees it.
    typedef struct packed {
        logic [NUM_W-1:0] compact_id;
        logic             is_new;
        logic [SRC_W-1:0] source_echo;
    } renumber_t;

    // One row of the directed table. Where 'typed' is set, the expected local
    // number and new flag are written into the row; otherwise they come from
    // the prediction.
    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic             first;
        logic             typed;
        logic [NUM_W-1:0] compact_id;
        logic             is_new;
    } beat_row_t;

    logic clk;
    logic rst_n;

    isr_in_if  items ();
    isr_out_if results ();

    index_first_seen_renumber #(
        .SOURCE_INDEX_BITS(TABLE_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items),
        .results(results)
    );

    // ------------------------------------------------------------------------
    // Renumbering prediction
    // ------------------------------------------------------------------------
    // Instead of clearing 2^TABLE_BITS seen flags at every mesh start, each
    // entry records the mesh in which it was last numbered. An entry counts as
    // seen only when that stamp equals the current mesh. The stamps start at
    // zero and the first mesh after reset is mesh one, so nothing counts as
    // seen after reset.
    int unsigned      seen_stamp [TABLE_DEPTH];
    logic [NUM_W-1:0] assigned_number [TABLE_DEPTH];
    int unsigned      mesh_stamp = 1;
    logic [COUNT_W-1:0] free_number = '0;

    // Results predicted for accepted source beats, oldest first.
    renumber_t pending_renumbers [$];

    int fail_count = 0;

    // Sender pacing: beats left in the current burst.
    int burst_left = 0;

    // Applies one source beat to the predicted table and returns its result.
    function automatic renumber_t predict_renumber(input logic [SRC_W-1:0] src,
                                                   input logic first);
        int unsigned slot;
        renumber_t   r;
        slot = int'(src) & (TABLE_DEPTH - 1);
        // A mesh start forgets every earlier index before this one is looked up.
        if (first)
        begin
            mesh_stamp  = mesh_stamp + 1;
            free_number = '0;
        end
        r.source_echo = src;
        r.is_new      = 1'b0;
        if (seen_stamp[slot] == mesh_stamp)
        begin
            r.compact_id = assigned_number[slot];
        end
        else if (free_number < NUMBER_LIMIT)
        begin
            r.compact_id          = free_number[NUM_W-1:0];
            r.is_new              = 1'b1;
            assigned_number[slot] = free_number[NUM_W-1:0];
            seen_stamp[slot]      = mesh_stamp;
            free_number           = free_number + 1'b1;
        end
        else
        begin
            // Numbering is used up: no entry is made and nothing changes.
            r.compact_id = EXHAUSTED_NUMBER;
        end
        return r;
    endfunction

    // Counts a failure and prints the first few of them.
    function automatic void note_failure(input string msg);
        fail_count = fail_count + 1;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Source indices for random meshes: mostly anywhere in the range, with
    // some weight on the low end, the top end and single-bit patterns.
    function automatic logic [SRC_W-1:0] pick_source();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            return SRC_W'($urandom);
        end
        else if (sel < 8)
        begin
            return SRC_W'($urandom_range(0, 255));
        end
        else if (sel < 9)
        begin
            return {SRC_W{1'b1}} - SRC_W'($urandom_range(0, 255));
        end
        return SRC_W'(1) << $urandom_range(0, SRC_W - 1);
    endfunction

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // The slowest correct run is the clearing pass after reset, then some 2.4k
    // beats, each taking the block's table reads and resolve step plus the
    // longest sender gap and sink stall. The limit allows many times that.
    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Presents one beat and holds it until the block takes it. Valid is left
    // high, so a following beat goes out on the next cycle without a gap. The
    // prediction is made at the accepting edge and queued.
    task automatic send_beat(input logic [SRC_W-1:0] src, input logic first,
                             input logic typed, input logic [NUM_W-1:0] given_local,
                             input logic given_new);
        renumber_t want;
        items.valid         <= 1'b1;
        items.vertex_id     <= src;
        items.first_of_mesh <= first;
        @(posedge clk);
        while (items.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        want = predict_renumber(src, first);
        if (typed)
        begin
            want.compact_id = given_local;
            want.is_new     = given_new;
        end
        pending_renumbers = {pending_renumbers, want};
    endtask

    // Bursts of random length separated by random gaps. A burst length of
    // zero gives an isolated beat, so gaps land on every cycle of an item.
    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
        end
        else
        begin
            items.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Stops sending until every result expected so far has arrived.
    task automatic drain();
        items.valid <= 1'b0;
        @(posedge clk);
        while (pending_renumbers.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Directed beats. The first ones run straight after reset without a mesh
    // start, to show that reset leaves every index unseen. The third mesh
    // revisits indices whose old numbers are again below the free counter,
    // which the block must still treat as new in this mesh. Back-to-back mesh
    // starts and the extremes of the source range are covered as well.
    beat_row_t directed_beats [23] = '{
        '{16'h1234, 1'b0, 1'b1, 16'd0, 1'b1},
        '{16'h1234, 1'b0, 1'b1, 16'd0, 1'b0},
        '{16'h0000, 1'b1, 1'b1, 16'd0, 1'b1},
        '{16'hFFFF, 1'b0, 1'b1, 16'd1, 1'b1},
        '{16'h0000, 1'b0, 1'b1, 16'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b1, 16'd1, 1'b0},
        '{16'h8000, 1'b0, 1'b1, 16'd2, 1'b1},
        '{16'h7FFF, 1'b0, 1'b1, 16'd3, 1'b1},
        '{16'h5555, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'hAAAA, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'hAAAA, 1'b1, 1'b1, 16'd0, 1'b1},
        '{16'h0001, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'h0002, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'h8000, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'h7FFF, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'h0001, 1'b1, 1'b1, 16'd0, 1'b1},
        '{16'h0001, 1'b1, 1'b1, 16'd0, 1'b1},
        '{16'h0001, 1'b0, 1'b1, 16'd0, 1'b0},
        '{16'hFFFE, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'h0100, 1'b0, 1'b0, 16'd0, 1'b0}
    };

    initial
    begin : stimulus
        logic [SRC_W-1:0] pool [400];
        logic [SRC_W-1:0] src;
        logic             first;
        int               mesh_len;
        int               pool_len;
        int               sent;
        bit               carry_on;

        rst_n               <= 1'b0;
        items.valid         <= 1'b0;
        items.vertex_id     <= '0;
        items.first_of_mesh <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_beats[i])
        begin
            send_beat(directed_beats[i].src, directed_beats[i].first,
                      directed_beats[i].typed, directed_beats[i].compact_id,
                      directed_beats[i].is_new);
            pace();
        end
        drain();

        // Random meshes. Each draws from a small pool so that repeats are
        // common, with some fresh indices mixed in. Now and then a mesh skips
        // its start flag and carries on the previous one, or a stray start
        // flag appears in the middle of a mesh.
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                mesh_len = $urandom_range(100, 400);
            end
            else
            begin
                mesh_len = $urandom_range(1, 60);
            end
            pool_len = $urandom_range(1, mesh_len);
            for (int p = 0; p < pool_len; p++)
            begin
                pool[p] = pick_source();
            end
            carry_on = ($urandom_range(0, 19) == 0);
            for (int k = 0; k < mesh_len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    src = pick_source();
                end
                else
                begin
                    src = pool[$urandom_range(0, pool_len - 1)];
                end
                first = ((k == 0) && !carry_on) || ($urandom_range(0, 99) == 0);
                send_beat(src, first, 1'b0, '0, 1'b0);
                pace();
                sent = sent + 1;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                drain();
            end
        end

        // Wait for the last results, then watch a little longer for extras.
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_renumbers.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sink side
    // ------------------------------------------------------------------------
    // Ready stretches of random length, mostly followed by a short stall.
    // A stretch with no stall after it runs on into the next, giving long runs.
    initial
    begin : sink_pattern
        results.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            results.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if ($urandom_range(0, 3) != 0)
            begin
                results.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Every accepted result beat is matched with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        renumber_t want;
        if (rst_n === 1'b1 && results.valid === 1'b1 && results.ready === 1'b1)
        begin
            if (pending_renumbers.size() == 0)
            begin
                note_failure($sformatf("unexpected beat local=%0d new=%0b src=%h",
                                       results.compact_id, results.is_new,
                                       results.source_echo));
            end
            else
            begin
                want = pending_renumbers.pop_front();
                if (results.compact_id !== want.compact_id
                    || results.is_new !== want.is_new
                    || results.source_echo !== want.source_echo)
                begin
                    note_failure($sformatf(
                        "expected local=%0d new=%0b src=%h, got local=%0d new=%0b src=%h",
                        want.compact_id, want.is_new, want.source_echo,
                        results.compact_id, results.is_new, results.source_echo));
                end
            end
        end
    end

endmodule

// File: filelist.f
design/isr_pkg.sv
design/isr_stream_if.sv
design/index_first_seen_renumber.sv
test/testbench.sv
